### design/tggt_pkg.sv
// Shared types and constants for the touch grid gesture tracker.
// Holds the electrode map, event and direction codes, register indexes and the
// command and status records between the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package tggt_pkg;

  localparam int ELECTRODES = 12;
  localparam int GRID_COLS  = 6;
  localparam int GRID_ROWS  = 6;

  // Port and field widths fixed by the interface.
  localparam int BITS_W    = 12;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_OUT_W = 18;
  localparam int DELTA_W   = 19;
  localparam int DIR_W     = 2;
  localparam int DISP_W    = 16;
  localparam int VEL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int DIST_W    = 16;
  localparam int SPEED_W   = 16;
  localparam int TAPD_W    = 24;
  localparam int SCALE_W   = 10;

  // Centroid arithmetic: grid index sums up to 15, touched count up to 6.
  localparam int SUM_W  = 4;
  localparam int CNT_W  = 3;
  localparam int EIDX_W = 4;

  typedef logic [EIDX_W-1:0] elec_idx_t;

  localparam elec_idx_t COL_ELEC [GRID_COLS] = '{4'd11, 4'd10, 4'd9, 4'd5, 4'd4, 4'd3};
  localparam elec_idx_t ROW_ELEC [GRID_ROWS] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd7, 4'd6};

  localparam logic [DIST_W-1:0]  RST_SWIPE_MIN_DIST  = 16'd20;
  localparam logic [SPEED_W-1:0] RST_SWIPE_MIN_SPEED = 16'd200;
  localparam logic [TIME_W-1:0]  RST_SWIPE_MAX_TIME  = 32'd300;
  localparam logic [TIME_W-1:0]  RST_TAP_MAX_TIME    = 32'd200;
  localparam logic [TAPD_W-1:0]  RST_TAP_MAX_DIST    = 24'd5;
  localparam logic [SCALE_W-1:0] RST_POS_SCALE       = 10'd100;

  localparam int TAP_MUL = 100;
  localparam int VEL_MUL = 1000;
  localparam int GRID_PITCH = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWIPE_MIN_DIST  = 3'd0,
    CFG_SWIPE_MIN_SPEED = 3'd1,
    CFG_SWIPE_MAX_TIME  = 3'd2,
    CFG_TAP_MAX_TIME    = 3'd3,
    CFG_TAP_MAX_DIST    = 3'd4,
    CFG_POS_SCALE       = 3'd5
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    EV_START = 3'd0,
    EV_MOVE  = 3'd1,
    EV_END   = 3'd2,
    EV_TAP   = 3'd3,
    EV_SWIPE = 3'd4
  } ev_kind_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_AX_PREP,
    S_AX_LAUNCH,
    S_AX_WAIT,
    S_TOUCH_EMIT,
    S_REL_PREP,
    S_REL_MUL,
    S_REL_LAUNCH,
    S_REL_WAIT,
    S_EMIT_END,
    S_EMIT_SECOND
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     ax_prep;
    logic     axis_y;
    logic     ax_fallback;
    logic     ax_store;
    logic     div_start;
    logic     div_vel;
    logic     touch_commit;
    logic     rel_prep;
    logic     rel_mul;
    logic     vel_store;
    logic     emit;
    ev_kind_t emit_kind;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic touching;
    logic bits_nz;
    logic cnt_zero;
    logic div_done;
    logic out_free;
    logic moved;
    logic is_tap;
    logic is_swipe;
  } sts_t;

endpackage

`default_nettype wire

### design/tggt_div.sv
// Restoring divider, one quotient bit per cycle, shared by the centroid and
// velocity calculations. Stand-alone apart from the timescale and net type.
`timescale 1ns / 1ps
`default_nettype none

module tggt_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W:0]   trial;
  logic             ge;

  // The divisor must stay stable for the whole division.
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### design/tggt_dp.sv
// Datapath of the gesture tracker: configuration registers, touch state,
// centroid and release arithmetic, and the result register.
// Depends on tggt_pkg and tggt_div.
`timescale 1ns / 1ps
`default_nettype none

module tggt_dp #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [tggt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tggt_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic [tggt_pkg::BITS_W-1:0]          touch_bits,
  input  wire logic [tggt_pkg::TIME_W-1:0]          now_ms,
  input  wire tggt_pkg::cmd_t                       cmd,
  output tggt_pkg::sts_t                            sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [tggt_pkg::KIND_W-1:0]               event_kind,
  output logic [tggt_pkg::POS_OUT_W-1:0]            pos_x,
  output logic [tggt_pkg::POS_OUT_W-1:0]            pos_y,
  output logic signed [tggt_pkg::DELTA_W-1:0]       delta_x,
  output logic signed [tggt_pkg::DELTA_W-1:0]       delta_y,
  output logic [tggt_pkg::TIME_W-1:0]               hold_ms,
  output logic [tggt_pkg::DIR_W-1:0]                swipe_dir,
  output logic [tggt_pkg::DISP_W-1:0]               displacement,
  output logic [tggt_pkg::VEL_W-1:0]                velocity,
  output logic                                      last
);

  localparam int F       = FRAC_BITS;
  localparam int POS_W   = tggt_pkg::SCALE_W + F;
  localparam int NUM_W   = POS_W + 10;
  localparam int DEN_W   = tggt_pkg::TIME_W;
  localparam int PROD_W  = tggt_pkg::SUM_W + tggt_pkg::SCALE_W;
  localparam int TAPP_W  = POS_W + 7;
  localparam int TAPV_W  = TAPP_W - F;
  localparam int QS_W    = NUM_W - F;
  localparam int MDC_W   = tggt_pkg::DIST_W + F;
  localparam int PEXT_W  = (POS_W > tggt_pkg::POS_OUT_W) ? POS_W : tggt_pkg::POS_OUT_W;
  localparam int DEXT_W  = (POS_W + 1 > tggt_pkg::DELTA_W) ? POS_W + 1 : tggt_pkg::DELTA_W;
  localparam int AXD_W   = 5;

  // Configuration registers.
  logic [tggt_pkg::DIST_W-1:0]  swipe_min_dist;
  logic [tggt_pkg::SPEED_W-1:0] swipe_min_speed;
  logic [tggt_pkg::TIME_W-1:0]  swipe_max_time;
  logic [tggt_pkg::TIME_W-1:0]  tap_max_time;
  logic [tggt_pkg::TAPD_W-1:0]  tap_max_dist;
  logic [tggt_pkg::SCALE_W-1:0] pos_scale;

  // Item and gesture state.
  logic [tggt_pkg::BITS_W-1:0] in_bits;
  logic [tggt_pkg::TIME_W-1:0] in_now;
  logic                        touching;
  logic [POS_W-1:0]            start_x;
  logic [POS_W-1:0]            start_y;
  logic [POS_W-1:0]            cur_x;
  logic [POS_W-1:0]            cur_y;
  logic [POS_W-1:0]            new_x;
  logic [POS_W-1:0]            new_y;
  logic [tggt_pkg::TIME_W-1:0] start_time;

  // Centroid operands.
  logic [NUM_W-1:0] ax_num;
  logic [AXD_W-1:0] ax_den;
  logic             ax_zero;

  // Release operands.
  logic [POS_W-1:0]            md;
  tggt_pkg::dir_t              dir;
  logic [tggt_pkg::TIME_W-1:0] dur;
  logic [TAPP_W-1:0]           tap_prod;
  logic [NUM_W-1:0]            vel_num;
  logic [tggt_pkg::VEL_W-1:0]  vel;

  // Combinational helpers.
  logic [tggt_pkg::SUM_W-1:0]  sum;
  logic [tggt_pkg::CNT_W-1:0]  cnt;
  logic [PROD_W-1:0]           ax_prod;
  logic [POS_W-1:0]            centre;
  logic [POS_W-1:0]            fallback;
  logic signed [POS_W:0]       mdx;
  logic signed [POS_W:0]       mdy;
  logic signed [POS_W:0]       rdx;
  logic signed [POS_W:0]       rdy;
  logic [POS_W:0]              rax;
  logic [POS_W:0]              ray;
  logic [tggt_pkg::TIME_W-1:0] cur_dur;
  logic [tggt_pkg::TIME_W-1:0] dur_adj;
  logic [TAPV_W-1:0]           tap_val;
  logic [QS_W-1:0]             qs;
  logic                        div_start;
  logic                        div_done;
  logic [NUM_W-1:0]            div_num;
  logic [DEN_W-1:0]            div_den;
  logic [NUM_W-1:0]            div_quo;
  logic [POS_W-1:0]            emit_px;
  logic [POS_W-1:0]            emit_py;
  logic [PEXT_W-1:0]           px_ext;
  logic [PEXT_W-1:0]           py_ext;
  logic signed [DEXT_W-1:0]    dx_ext;
  logic signed [DEXT_W-1:0]    dy_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_min_dist  <= tggt_pkg::RST_SWIPE_MIN_DIST;
      swipe_min_speed <= tggt_pkg::RST_SWIPE_MIN_SPEED;
      swipe_max_time  <= tggt_pkg::RST_SWIPE_MAX_TIME;
      tap_max_time    <= tggt_pkg::RST_TAP_MAX_TIME;
      tap_max_dist    <= tggt_pkg::RST_TAP_MAX_DIST;
      pos_scale       <= tggt_pkg::RST_POS_SCALE;
    end else if (cfg_we) begin
      unique case (tggt_pkg::cfg_idx_t'(cfg_index))
        tggt_pkg::CFG_SWIPE_MIN_DIST:  swipe_min_dist  <= cfg_data[tggt_pkg::DIST_W-1:0];
        tggt_pkg::CFG_SWIPE_MIN_SPEED: swipe_min_speed <= cfg_data[tggt_pkg::SPEED_W-1:0];
        tggt_pkg::CFG_SWIPE_MAX_TIME:  swipe_max_time  <= cfg_data[tggt_pkg::TIME_W-1:0];
        tggt_pkg::CFG_TAP_MAX_TIME:    tap_max_time    <= cfg_data[tggt_pkg::TIME_W-1:0];
        tggt_pkg::CFG_TAP_MAX_DIST:    tap_max_dist    <= cfg_data[tggt_pkg::TAPD_W-1:0];
        tggt_pkg::CFG_POS_SCALE:       pos_scale       <= cfg_data[tggt_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sum of grid indexes and count of touched electrodes on the chosen axis.
  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < tggt_pkg::GRID_COLS; i++) begin
      if (in_bits[cmd.axis_y ? tggt_pkg::ROW_ELEC[i] : tggt_pkg::COL_ELEC[i]]) begin
        sum = sum + tggt_pkg::SUM_W'(i);
        cnt = cnt + 1'b1;
      end
    end
    ax_prod = PROD_W'(sum) * PROD_W'(pos_scale);
  end

  always_comb begin
    centre   = POS_W'(pos_scale) << (F - 1);
    fallback = touching ? (cmd.axis_y ? cur_y : cur_x) : centre;
    mdx      = $signed({1'b0, new_x}) - $signed({1'b0, cur_x});
    mdy      = $signed({1'b0, new_y}) - $signed({1'b0, cur_y});
    rdx      = $signed({1'b0, cur_x}) - $signed({1'b0, start_x});
    rdy      = $signed({1'b0, cur_y}) - $signed({1'b0, start_y});
    rax      = rdx[POS_W] ? (POS_W + 1)'(-rdx) : rdx;
    ray      = rdy[POS_W] ? (POS_W + 1)'(-rdy) : rdy;
    cur_dur  = in_now - start_time;
    dur_adj  = (dur == '0) ? tggt_pkg::TIME_W'(1) : dur;
    tap_val  = tap_prod[TAPP_W-1:F];
    qs       = div_quo[NUM_W-1:F];
  end

  // Inputs and centroid.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_bits <= touch_bits;
      in_now  <= now_ms;
    end
    if (cmd.ax_prep) begin
      ax_num  <= NUM_W'(ax_prod) << F;
      ax_den  <= AXD_W'(cnt) * AXD_W'(tggt_pkg::GRID_PITCH);
      ax_zero <= (cnt == '0);
    end
    if (cmd.ax_fallback || cmd.ax_store) begin
      if (cmd.axis_y) begin
        new_y <= cmd.ax_fallback ? fallback : div_quo[POS_W-1:0];
      end else begin
        new_x <= cmd.ax_fallback ? fallback : div_quo[POS_W-1:0];
      end
    end
  end

  // Touch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      touching <= 1'b0;
    end else if (cmd.touch_commit) begin
      touching <= 1'b1;
    end else if (cmd.emit && cmd.emit_kind == tggt_pkg::EV_END) begin
      touching <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.touch_commit) begin
      cur_x <= new_x;
      cur_y <= new_y;
      if (!touching) begin
        start_x    <= new_x;
        start_y    <= new_y;
        start_time <= in_now;
      end
    end
  end

  // Release: largest axis displacement, direction and duration, then products.
  always_ff @(posedge clk) begin
    if (cmd.rel_prep) begin
      md  <= (rax > ray) ? rax[POS_W-1:0] : ray[POS_W-1:0];
      dur <= cur_dur;
      if (rax > ray) begin
        dir <= (!rdx[POS_W] && rdx != '0) ? tggt_pkg::DIR_RIGHT : tggt_pkg::DIR_LEFT;
      end else begin
        dir <= (!rdy[POS_W] && rdy != '0) ? tggt_pkg::DIR_DOWN : tggt_pkg::DIR_UP;
      end
    end
    if (cmd.rel_mul) begin
      tap_prod <= TAPP_W'(md) * TAPP_W'(tggt_pkg::TAP_MUL);
      vel_num  <= NUM_W'(md) * NUM_W'(tggt_pkg::VEL_MUL);
    end
    if (cmd.vel_store) begin
      vel <= (|qs[QS_W-1:tggt_pkg::VEL_W]) ? '1 : qs[tggt_pkg::VEL_W-1:0];
    end
  end

  assign div_start = cmd.div_start;
  assign div_num   = cmd.div_vel ? vel_num : ax_num;
  assign div_den   = cmd.div_vel ? dur_adj : DEN_W'(ax_den);

  tggt_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sts.touching = touching;
    sts.bits_nz  = |in_bits;
    sts.cnt_zero = ax_zero;
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
    sts.moved    = (new_x != cur_x) || (new_y != cur_y);
    sts.is_tap   = (dur <= tap_max_time) &&
                   (tggt_pkg::TAPD_W'(tap_val) <= tap_max_dist);
    sts.is_swipe = (MDC_W'(md) >= {swipe_min_dist, {F{1'b0}}}) &&
                   (dur_adj <= swipe_max_time) && (vel >= swipe_min_speed);
  end

  // Result fields for the event being issued.
  always_comb begin
    unique case (cmd.emit_kind)
      tggt_pkg::EV_START, tggt_pkg::EV_MOVE: begin
        emit_px = new_x;
        emit_py = new_y;
      end
      tggt_pkg::EV_END: begin
        emit_px = cur_x;
        emit_py = cur_y;
      end
      tggt_pkg::EV_TAP: begin
        emit_px = start_x;
        emit_py = start_y;
      end
      default: begin
        emit_px = '0;
        emit_py = '0;
      end
    endcase
    px_ext = PEXT_W'(emit_px);
    py_ext = PEXT_W'(emit_py);
    dx_ext = DEXT_W'(mdx);
    dy_ext = DEXT_W'(mdy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_kind   <= cmd.emit_kind;
      pos_x        <= px_ext[tggt_pkg::POS_OUT_W-1:0];
      pos_y        <= py_ext[tggt_pkg::POS_OUT_W-1:0];
      delta_x      <= '0;
      delta_y      <= '0;
      hold_ms      <= '0;
      swipe_dir    <= '0;
      displacement <= '0;
      velocity     <= '0;
      last         <= cmd.emit_last;
      if (cmd.emit_kind == tggt_pkg::EV_MOVE) begin
        delta_x <= dx_ext[tggt_pkg::DELTA_W-1:0];
        delta_y <= dy_ext[tggt_pkg::DELTA_W-1:0];
      end
      if (cmd.emit_kind == tggt_pkg::EV_END || cmd.emit_kind == tggt_pkg::EV_TAP ||
          cmd.emit_kind == tggt_pkg::EV_SWIPE) begin
        hold_ms <= dur;
      end
      if (cmd.emit_kind == tggt_pkg::EV_SWIPE) begin
        swipe_dir    <= dir;
        displacement <= tggt_pkg::DISP_W'(md[POS_W-1:F]);
        velocity     <= vel;
      end
    end
  end

endmodule

`default_nettype wire

### design/tggt_ctrl.sv
// Controller of the gesture tracker: sequences the centroid divisions, the
// release analysis and the issue of results. Depends on tggt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tggt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tggt_pkg::sts_t sts,
  output tggt_pkg::cmd_t      cmd
);

  tggt_pkg::state_t state;
  tggt_pkg::state_t state_next;
  logic             axis;
  logic             axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tggt_pkg::S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.axis_y = axis;

    unique case (state)
      tggt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tggt_pkg::S_DECIDE;
        end
      end
      tggt_pkg::S_DECIDE: begin
        if (sts.bits_nz) begin
          axis_next  = 1'b0;
          state_next = tggt_pkg::S_AX_PREP;
        end else if (sts.touching) begin
          state_next = tggt_pkg::S_REL_PREP;
        end else begin
          state_next = tggt_pkg::S_IDLE;
        end
      end
      tggt_pkg::S_AX_PREP: begin
        cmd.ax_prep = 1'b1;
        state_next  = tggt_pkg::S_AX_LAUNCH;
      end
      tggt_pkg::S_AX_LAUNCH: begin
        if (sts.cnt_zero) begin
          cmd.ax_fallback = 1'b1;
          axis_next       = 1'b1;
          state_next      = axis ? tggt_pkg::S_TOUCH_EMIT : tggt_pkg::S_AX_PREP;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = tggt_pkg::S_AX_WAIT;
        end
      end
      tggt_pkg::S_AX_WAIT: begin
        if (sts.div_done) begin
          cmd.ax_store = 1'b1;
          axis_next    = 1'b1;
          state_next   = axis ? tggt_pkg::S_TOUCH_EMIT : tggt_pkg::S_AX_PREP;
        end
      end
      tggt_pkg::S_TOUCH_EMIT: begin
        // A held touch whose position did not change only updates the state.
        if (sts.touching && !sts.moved) begin
          cmd.touch_commit = 1'b1;
          state_next       = tggt_pkg::S_IDLE;
        end else if (sts.out_free) begin
          cmd.touch_commit = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_kind    = sts.touching ? tggt_pkg::EV_MOVE : tggt_pkg::EV_START;
          cmd.emit_last    = 1'b1;
          state_next       = tggt_pkg::S_IDLE;
        end
      end
      tggt_pkg::S_REL_PREP: begin
        cmd.rel_prep = 1'b1;
        state_next   = tggt_pkg::S_REL_MUL;
      end
      tggt_pkg::S_REL_MUL: begin
        cmd.rel_mul = 1'b1;
        state_next  = tggt_pkg::S_REL_LAUNCH;
      end
      tggt_pkg::S_REL_LAUNCH: begin
        if (sts.is_tap) begin
          state_next = tggt_pkg::S_EMIT_END;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_vel   = 1'b1;
          state_next    = tggt_pkg::S_REL_WAIT;
        end
      end
      tggt_pkg::S_REL_WAIT: begin
        cmd.div_vel = 1'b1;
        if (sts.div_done) begin
          cmd.vel_store = 1'b1;
          state_next    = tggt_pkg::S_EMIT_END;
        end
      end
      tggt_pkg::S_EMIT_END: begin
        cmd.div_vel = 1'b1;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = tggt_pkg::EV_END;
          cmd.emit_last = !(sts.is_tap || sts.is_swipe);
          state_next    = (sts.is_tap || sts.is_swipe) ? tggt_pkg::S_EMIT_SECOND
                                                       : tggt_pkg::S_IDLE;
        end
      end
      tggt_pkg::S_EMIT_SECOND: begin
        cmd.div_vel = 1'b1;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sts.is_tap ? tggt_pkg::EV_TAP : tggt_pkg::EV_SWIPE;
          cmd.emit_last = 1'b1;
          state_next    = tggt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tggt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/touch_grid_gesture_tracker.sv
// Touch grid gesture tracker: turns electrode polls into touch events.
//
// Input channel (in_valid/in_ready): one transaction is a poll, touch_bits and
// now_ms. Output channel (out_valid/out_ready): zero, one or two transactions
// per poll (start, move, end, tap, swipe); last marks the final one of a poll.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user is bound to this, and the block itself does not enforce it. One poll
// is handled at a time; a shared restoring divider of N = FRAC_BITS+20 bits
// (28 by default) gives one quotient bit per cycle while it is busy. A poll
// with no touch while released uses no division; a poll with a touch divides
// once per axis, skipping an axis with no touched electrode; a release
// divides for the velocity unless it is a tap.
// The result register decouples the sides: the next poll is taken while a
// finished result still waits. A stalled receiver holds the controller only
// when it has a new result to issue. Reset restores the default thresholds,
// clears the touch state and empties the result register; no clearing pass.
// Depends on tggt_pkg, tggt_ctrl, tggt_dp and tggt_div.
`timescale 1ns / 1ps
`default_nettype none

module touch_grid_gesture_tracker #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [tggt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tggt_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tggt_pkg::BITS_W-1:0]           touch_bits,
  input  wire logic [tggt_pkg::TIME_W-1:0]           now_ms,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tggt_pkg::KIND_W-1:0]                event_kind,
  output logic [tggt_pkg::POS_OUT_W-1:0]             pos_x,
  output logic [tggt_pkg::POS_OUT_W-1:0]             pos_y,
  output logic signed [tggt_pkg::DELTA_W-1:0]        delta_x,
  output logic signed [tggt_pkg::DELTA_W-1:0]        delta_y,
  output logic [tggt_pkg::TIME_W-1:0]                hold_ms,
  output logic [tggt_pkg::DIR_W-1:0]                 swipe_dir,
  output logic [tggt_pkg::DISP_W-1:0]                displacement,
  output logic [tggt_pkg::VEL_W-1:0]                 velocity,
  output logic                                       last
);

  tggt_pkg::cmd_t cmd;
  tggt_pkg::sts_t sts;

  tggt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tggt_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .touch_bits   (touch_bits),
    .now_ms       (now_ms),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .hold_ms      (hold_ms),
    .swipe_dir    (swipe_dir),
    .displacement (displacement),
    .velocity     (velocity),
    .last         (last)
  );

  // While an end event that is not the last result is taken, the tap or swipe
  // is still pending, so no poll can be accepted.
  a_end_then_second: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && event_kind == tggt_pkg::EV_END && !last) |-> !in_ready)
    else $error("poll accepted between an end event and its tap or swipe");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == tggt_pkg::EV_START || event_kind == tggt_pkg::EV_MOVE ||
                   event_kind == tggt_pkg::EV_TAP || event_kind == tggt_pkg::EV_SWIPE))
    |-> last)
    else $error("start, move, tap or swipe event without last");

  a_swipe_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == tggt_pkg::EV_SWIPE) |-> (pos_x == '0 && pos_y == '0 &&
                                                         delta_x == '0 && delta_y == '0))
    else $error("swipe event carries a position or delta");

endmodule

`default_nettype wire

### tb/touch_event_checker.sv
// Event checker for the touch grid gesture tracker testbench.
// Watches the register writes and both handshake channels, predicts each poll's events
// and compares them field by field with what the block gives; depends on tggt_pkg.
`timescale 1ns / 1ps

module touch_event_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tggt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tggt_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [tggt_pkg::BITS_W-1:0]           touch_bits,
  input  logic [tggt_pkg::TIME_W-1:0]           now_ms,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [tggt_pkg::KIND_W-1:0]           event_kind,
  input  logic [tggt_pkg::POS_OUT_W-1:0]        pos_x,
  input  logic [tggt_pkg::POS_OUT_W-1:0]        pos_y,
  input  logic signed [tggt_pkg::DELTA_W-1:0]   delta_x,
  input  logic signed [tggt_pkg::DELTA_W-1:0]   delta_y,
  input  logic [tggt_pkg::TIME_W-1:0]           hold_ms,
  input  logic [tggt_pkg::DIR_W-1:0]            swipe_dir,
  input  logic [tggt_pkg::DISP_W-1:0]           displacement,
  input  logic [tggt_pkg::VEL_W-1:0]            velocity,
  input  logic                                  last,
  output int                                    fault_count,
  output int                                    pending
);
  import tggt_pkg::*;

  typedef longint unsigned wide_t;

  localparam wide_t VEL_TOP = (wide_t'(1) << VEL_W) - 1;

  typedef struct packed {
    ev_kind_t                   kind;
    logic [POS_OUT_W-1:0]       px;
    logic [POS_OUT_W-1:0]       py;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic [TIME_W-1:0]          dur;
    dir_t                       dir;
    logic [DISP_W-1:0]          disp;
    logic [VEL_W-1:0]           vel;
    logic                       last;
  } touch_event_t;

  touch_event_t due_events[$];

  logic [DIST_W-1:0]  min_dist;
  logic [SPEED_W-1:0] min_speed;
  logic [TIME_W-1:0]  swipe_time_max;
  logic [TIME_W-1:0]  tap_time_max;
  logic [TAPD_W-1:0]  tap_dist_max;
  logic [SCALE_W-1:0] scale;

  logic              held;
  wide_t             x0, y0, xc, yc;
  logic [TIME_W-1:0] t0;

  int           misses = 0;
  touch_event_t want;
  bit           bad;

  initial begin
    fault_count = 0;
    pending = 0;
  end

  // Averages the touched lines of one axis; an axis with nothing touched keeps the
  // value handed in.
  function automatic wide_t centroid(logic [BITS_W-1:0] bits, bit rows, wide_t keep);
    wide_t sum;
    wide_t cnt;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < GRID_COLS; i++) begin
      if (bits[rows ? ROW_ELEC[i] : COL_ELEC[i]]) begin
        sum += wide_t'(i);
        cnt += 1;
      end
    end
    if (cnt == 0) return keep;
    return ((sum * scale) << FRAC_BITS) / (cnt * GRID_PITCH);
  endfunction

  function automatic touch_event_t blank_event(ev_kind_t kind, wide_t px, wide_t py,
                                               longint dx, longint dy,
                                               logic [TIME_W-1:0] dur);
    touch_event_t e;
    e.kind = kind;
    e.px   = POS_OUT_W'(px);
    e.py   = POS_OUT_W'(py);
    e.dx   = DELTA_W'(dx);
    e.dy   = DELTA_W'(dy);
    e.dur  = dur;
    e.dir  = DIR_LEFT;
    e.disp = '0;
    e.vel  = '0;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic void track_poll(logic [BITS_W-1:0] bits, logic [TIME_W-1:0] now);
    wide_t             x, y, centre, ax, ay, md, d, vel;
    longint            dx, dy;
    logic [TIME_W-1:0] dur;
    touch_event_t      e;
    int                queued;
    queued = due_events.size();
    if (!held && bits != '0) begin
      centre = (wide_t'(scale) << FRAC_BITS) / 2;
      x = centroid(bits, 1'b0, centre);
      y = centroid(bits, 1'b1, centre);
      x0 = x;
      xc = x;
      y0 = y;
      yc = y;
      t0 = now;
      held = 1'b1;
      due_events.push_back(blank_event(EV_START, x, y, 0, 0, '0));
    end else if (held && bits != '0) begin
      x = centroid(bits, 1'b0, xc);
      y = centroid(bits, 1'b1, yc);
      dx = longint'(x) - longint'(xc);
      dy = longint'(y) - longint'(yc);
      if (dx != 0 || dy != 0) due_events.push_back(blank_event(EV_MOVE, x, y, dx, dy, '0));
      xc = x;
      yc = y;
    end else if (held) begin
      dur = now - t0;
      dx = longint'(xc) - longint'(x0);
      dy = longint'(yc) - longint'(y0);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      md = (ax > ay) ? ax : ay;
      due_events.push_back(blank_event(EV_END, xc, yc, 0, 0, dur));
      if (dur <= tap_time_max && ((md * TAP_MUL) >> FRAC_BITS) <= tap_dist_max) begin
        due_events.push_back(blank_event(EV_TAP, x0, y0, 0, 0, dur));
      end else begin
        // A release in the same millisecond as the touch is timed as one millisecond.
        d = (dur == '0) ? 1 : wide_t'(dur);
        vel = ((md * VEL_MUL) / d) >> FRAC_BITS;
        if (vel > VEL_TOP) vel = VEL_TOP;
        if (md >= (wide_t'(min_dist) << FRAC_BITS) && d <= swipe_time_max &&
            vel >= min_speed) begin
          e = blank_event(EV_SWIPE, 0, 0, 0, 0, dur);
          if (ax > ay) e.dir = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
          else e.dir = (dy > 0) ? DIR_DOWN : DIR_UP;
          e.disp = DISP_W'(md >> FRAC_BITS);
          e.vel = VEL_W'(vel);
          due_events.push_back(e);
        end
      end
      held = 1'b0;
    end
    if (due_events.size() > queued) begin
      e = due_events.pop_back();
      e.last = 1'b1;
      due_events.push_back(e);
    end
  endfunction

  function automatic bit field_differs(string name, longint expected, longint actual);
    if (expected == actual) return 1'b0;
    $error("%s: expected %0d, got %0d", name, expected, actual);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      min_dist       = RST_SWIPE_MIN_DIST;
      min_speed      = RST_SWIPE_MIN_SPEED;
      swipe_time_max = RST_SWIPE_MAX_TIME;
      tap_time_max   = RST_TAP_MAX_TIME;
      tap_dist_max   = RST_TAP_MAX_DIST;
      scale          = RST_POS_SCALE;
      held = 1'b0;
      x0 = 0;
      y0 = 0;
      xc = 0;
      yc = 0;
      t0 = '0;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWIPE_MIN_DIST:  min_dist       = DIST_W'(cfg_data);
          CFG_SWIPE_MIN_SPEED: min_speed      = SPEED_W'(cfg_data);
          CFG_SWIPE_MAX_TIME:  swipe_time_max = TIME_W'(cfg_data);
          CFG_TAP_MAX_TIME:    tap_time_max   = TIME_W'(cfg_data);
          CFG_TAP_MAX_DIST:    tap_dist_max   = TAPD_W'(cfg_data);
          CFG_POS_SCALE:       scale          = SCALE_W'(cfg_data);
          default: ;
        endcase
      end
      // Results are taken before the poll of the same edge, which cannot have produced any yet.
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected transaction: event_kind %0d", event_kind);
          misses++;
        end else begin
          want = due_events.pop_front();
          bad = field_differs("event_kind", want.kind, event_kind)
              | field_differs("pos_x", want.px, pos_x)
              | field_differs("pos_y", want.py, pos_y)
              | field_differs("delta_x", $signed(want.dx), delta_x)
              | field_differs("delta_y", $signed(want.dy), delta_y)
              | field_differs("hold_ms", want.dur, hold_ms)
              | field_differs("swipe_dir", want.dir, swipe_dir)
              | field_differs("displacement", want.disp, displacement)
              | field_differs("velocity", want.vel, velocity)
              | field_differs("last", want.last, last);
          if (bad) misses++;
        end
      end
      if (in_valid && in_ready) track_poll(touch_bits, now_ms);
    end
    fault_count <= misses;
    pending <= due_events.size();
  end

endmodule

### tb/tb_touch_grid_gesture_tracker.sv
// Top of the touch grid gesture tracker testbench: clock, reset, polls, register phases.
// Instantiates the tracker and touch_event_checker; uses tggt_pkg for widths and codes.
`timescale 1ns / 1ps

module tb_touch_grid_gesture_tracker;
  import tggt_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int SETTLE      = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_POLLS = 106;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_W-1:0]          cfg_data   = '0;
  logic                      in_valid   = 1'b0;
  logic [BITS_W-1:0]         touch_bits = '0;
  logic [TIME_W-1:0]         now_ms     = '0;
  logic                      out_ready  = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [KIND_W-1:0]         event_kind;
  logic [POS_OUT_W-1:0]      pos_x;
  logic [POS_OUT_W-1:0]      pos_y;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [TIME_W-1:0]         hold_ms;
  logic [DIR_W-1:0]          swipe_dir;
  logic [DISP_W-1:0]         displacement;
  logic [VEL_W-1:0]          velocity;
  logic                      last;

  int fault_count;
  int pending;
  bit steady       = 1'b0;
  int stall_left   = 0;
  int ready_pause  = 0;
  int quiet_cycles = 0;
  int polls_sent   = 0;
  int target;
  int pick;

  logic [CFG_W-1:0] regs_next [6];

  touch_grid_gesture_tracker #(.FRAC_BITS(FRAC_BITS)) uut (.*);

  touch_event_checker #(.FRAC_BITS(FRAC_BITS)) events_chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [BITS_W-1:0] grid_bits(logic [5:0] cols, logic [5:0] rows);
    logic [BITS_W-1:0] b;
    b = '0;
    for (int i = 0; i < GRID_COLS; i++) if (cols[i]) b[COL_ELEC[i]] = 1'b1;
    for (int i = 0; i < GRID_ROWS; i++) if (rows[i]) b[ROW_ELEC[i]] = 1'b1;
    return b;
  endfunction

  // Single-line touches make clean swipes; one-axis masks exercise the missing axis.
  function automatic logic [BITS_W-1:0] pick_touch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return grid_bits(6'd1 << $urandom_range(0, 5), 6'd1 << $urandom_range(0, 5));
    if (r < 45) return grid_bits(6'($urandom_range(1, 63)), 6'd0);
    if (r < 60) return grid_bits(6'd0, 6'($urandom_range(1, 63)));
    return BITS_W'($urandom_range(1, 4095));
  endfunction

  function automatic logic [TIME_W-1:0] pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 50) return $urandom_range(1, 250);
    if (r < 85) return $urandom_range(1, 1200);
    return $urandom();
  endfunction

  task automatic push_poll(input logic [BITS_W-1:0] bits, input logic [TIME_W-1:0] t);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    touch_bits <= bits;
    now_ms     <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Indexes past the last register are written as well; the block must ignore them.
  task automatic program_regs();
    for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= (k < 6) ? regs_next[k] : CFG_W'($urandom());
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic gesture();
    logic [TIME_W-1:0] t_start;
    logic [BITS_W-1:0] bits;
    int                moves;
    t_start = $urandom();
    bits = pick_touch();
    push_poll(bits, t_start);
    polls_sent++;
    moves = $urandom_range(0, 4);
    repeat (moves) begin
      if ($urandom_range(0, 2) != 0) bits = pick_touch();
      push_poll(bits, $urandom());
      polls_sent++;
    end
    // Now and then the release is lost, so the next touch lands on a held one.
    if ($urandom_range(0, 9) != 0) begin
      push_poll('0, t_start + pick_hold());
      polls_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      ready_pause = pause_len();
      stall_left <= ready_pause;
      out_ready <= (ready_pause == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_touch_grid_gesture_tracker: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed polls at the reset thresholds.
    push_poll('0, 32'd1000);
    push_poll(grid_bits(6'b000001, 6'b000001), 32'd1000);
    push_poll(grid_bits(6'b100000, 6'b000001), 32'd1010);
    push_poll(grid_bits(6'b100000, 6'b000001), 32'd1020);
    push_poll('0, 32'd1050);
    push_poll(grid_bits(6'b100000, 6'b000100), 32'd2000);
    push_poll(grid_bits(6'b000001, 6'b000100), 32'd2040);
    push_poll('0, 32'd2100);
    push_poll(grid_bits(6'b000100, 6'b100000), 32'd3000);
    push_poll(grid_bits(6'b000100, 6'b000001), 32'd3040);
    push_poll('0, 32'd3100);
    // Equal travel on both axes is judged on the y axis.
    push_poll(grid_bits(6'b000001, 6'b000001), 32'd4000);
    push_poll(grid_bits(6'b100000, 6'b100000), 32'd4040);
    push_poll('0, 32'd4100);
    push_poll({BITS_W{1'b1}}, 32'd5000);
    push_poll('0, 32'd5000);
    // Released in the same millisecond after a full-width move: velocity saturates.
    push_poll(grid_bits(6'b000001, 6'b000001), 32'd6000);
    push_poll(grid_bits(6'b100000, 6'b000001), 32'd6003);
    push_poll('0, 32'd6000);
    push_poll(grid_bits(6'b000010, 6'b000000), 32'd7000);
    push_poll(grid_bits(6'b000000, 6'b001000), 32'd7010);
    push_poll('0, 32'd7500);
    push_poll(grid_bits(6'b000010, 6'b000010), 32'hFFFF_FFF0);
    push_poll('0, 32'h0000_0010);
    drain(SETTLE);

    for (int p = 0; p < PHASES; p++) begin
      regs_next[CFG_SWIPE_MIN_DIST]  = $urandom_range(0, 60);
      regs_next[CFG_SWIPE_MIN_SPEED] = $urandom_range(0, 3000);
      regs_next[CFG_SWIPE_MAX_TIME]  = $urandom_range(0, 1000);
      regs_next[CFG_TAP_MAX_TIME]    = $urandom_range(0, 400);
      regs_next[CFG_TAP_MAX_DIST]    = $urandom_range(0, 300);
      regs_next[CFG_POS_SCALE]       = $urandom_range(1, 1000);
      case (p)
        0: begin
          foreach (regs_next[k]) regs_next[k] = '0;
        end
        1: begin
          regs_next[CFG_SWIPE_MIN_DIST]  = CFG_W'({DIST_W{1'b1}});
          regs_next[CFG_SWIPE_MIN_SPEED] = CFG_W'({SPEED_W{1'b1}});
          regs_next[CFG_SWIPE_MAX_TIME]  = CFG_W'({TIME_W{1'b1}});
          regs_next[CFG_TAP_MAX_TIME]    = CFG_W'({TIME_W{1'b1}});
          regs_next[CFG_TAP_MAX_DIST]    = CFG_W'({TAPD_W{1'b1}});
          regs_next[CFG_POS_SCALE]       = CFG_W'({SCALE_W{1'b1}});
        end
        2: begin
          regs_next[CFG_SWIPE_MIN_DIST]  = CFG_W'(RST_SWIPE_MIN_DIST);
          regs_next[CFG_SWIPE_MIN_SPEED] = CFG_W'(RST_SWIPE_MIN_SPEED);
          regs_next[CFG_SWIPE_MAX_TIME]  = CFG_W'(RST_SWIPE_MAX_TIME);
          regs_next[CFG_TAP_MAX_TIME]    = CFG_W'(RST_TAP_MAX_TIME);
          regs_next[CFG_TAP_MAX_DIST]    = CFG_W'(RST_TAP_MAX_DIST);
          regs_next[CFG_POS_SCALE]       = 1;
        end
        3: regs_next[CFG_POS_SCALE] = 1000;
        default: ;
      endcase
      steady = (p == 2 || p == 5);
      program_regs();
      target = polls_sent + PHASE_POLLS;
      while (polls_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) push_poll('0, $urandom());
        else if (pick < 11) drain(0);
        else gesture();
      end
      drain(SETTLE);
    end

    if (fault_count == 0 && pending == 0) $display("tb_touch_grid_gesture_tracker: done, clean");
    else $display("tb_touch_grid_gesture_tracker: done, errors");
    $finish;
  end

endmodule
